// File: hdl/prl_pkg.sv
// ----------------------------------------------------------------------------
// prl_pkg
// shared widths, action codes and controller/datapath structs for the
// positional record list
// ----------------------------------------------------------------------------
`default_nettype none

package prl_pkg;

    // default sizing, handed down from the top level
    localparam int DEPTH_DEF      = 64;
    localparam int NAME_BYTES_DEF = 8;

    // fixed field widths of the request and response words
    localparam int ACTION_W = 2;
    localparam int POS_W    = 6;
    localparam int WORD_W   = 64;
    localparam int AGE_W    = 8;
    localparam int LEN_W    = 7;

    typedef enum logic [ACTION_W-1:0] {
        ACT_APPEND = 2'd0,
        ACT_READ   = 2'd1,
        ACT_DELETE = 2'd2,
        ACT_INSERT = 2'd3
    } action_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic write_new;
        logic read_issue;
        logic shift_init;
        logic shift_step;
        logic result_load;
    } prl_cmd_t;

    // datapath to controller
    typedef struct packed {
        action_t action;
        logic    refused;
        logic    shift_done;
        logic    out_free;
    } prl_stat_t;

endpackage

`default_nettype wire

// File: hdl/prl_req_if.sv
// ----------------------------------------------------------------------------
// prl_req_if
// request channel: valid/ready handshake with one request word
// ----------------------------------------------------------------------------
`default_nettype none

interface prl_req_if;
    import prl_pkg::*;

    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [POS_W-1:0]    position;
    logic [WORD_W-1:0]   entry_id;
    logic [WORD_W-1:0]   entry_name;
    logic [AGE_W-1:0]    entry_age;

    modport source (
        output valid, action, position, entry_id, entry_name, entry_age,
        input  ready
    );

    modport sink (
        input  valid, action, position, entry_id, entry_name, entry_age,
        output ready
    );

endinterface

`default_nettype wire

// File: hdl/prl_rsp_if.sv
// ----------------------------------------------------------------------------
// prl_rsp_if
// response channel: valid/ready handshake with one response word
// ----------------------------------------------------------------------------
`default_nettype none

interface prl_rsp_if;
    import prl_pkg::*;

    logic              valid;
    logic              ready;
    logic              status;
    logic [WORD_W-1:0] read_id;
    logic [WORD_W-1:0] read_name;
    logic [AGE_W-1:0]  read_age;
    logic [LEN_W-1:0]  list_length;

    modport source (
        output valid, status, read_id, read_name, read_age, list_length,
        input  ready
    );

    modport sink (
        input  valid, status, read_id, read_name, read_age, list_length,
        output ready
    );

endinterface

`default_nettype wire

// File: hdl/prl_ram.sv
// ----------------------------------------------------------------------------
// prl_ram
// generic simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module prl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: hdl/prl_ctrl.sv
// ----------------------------------------------------------------------------
// prl_ctrl
// request sequencer: decides, runs the shift loop and hands off the response
// ----------------------------------------------------------------------------
`default_nettype none

module prl_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    output logic                     req_ready,
    input  wire prl_pkg::prl_stat_t  stat,
    output prl_pkg::prl_cmd_t        cmd
);
    import prl_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECIDE,
        S_SHIFT,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (stat.refused)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    unique case (stat.action)
                        ACT_APPEND:
                        begin
                            cmd.write_new = 1'b1;
                            state_next    = S_DONE;
                        end
                        ACT_READ:
                        begin
                            cmd.read_issue = 1'b1;
                            state_next     = S_DONE;
                        end
                        ACT_DELETE, ACT_INSERT:
                        begin
                            cmd.shift_init = 1'b1;
                            state_next     = S_SHIFT;
                        end
                    endcase
                end
            end
            S_SHIFT:
            begin
                if (stat.shift_done)
                begin
                    // slot at position is free once the copies drain
                    cmd.write_new = (stat.action == ACT_INSERT);
                    state_next    = S_DONE;
                end
                else
                begin
                    cmd.shift_step = 1'b1;
                end
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.result_load = 1'b1;
                    state_next      = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// File: hdl/prl_datapath.sv
// ----------------------------------------------------------------------------
// prl_datapath
// record store, length counter, shift pointers and response register
// ----------------------------------------------------------------------------
`default_nettype none

module prl_datapath #(
    parameter int DEPTH      = prl_pkg::DEPTH_DEF,
    parameter int NAME_BYTES = prl_pkg::NAME_BYTES_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire prl_pkg::prl_cmd_t             cmd,
    output prl_pkg::prl_stat_t                 stat,
    input  wire logic [prl_pkg::ACTION_W-1:0]  req_action,
    input  wire logic [prl_pkg::POS_W-1:0]     req_position,
    input  wire logic [prl_pkg::WORD_W-1:0]    req_entry_id,
    input  wire logic [prl_pkg::WORD_W-1:0]    req_entry_name,
    input  wire logic [prl_pkg::AGE_W-1:0]     req_entry_age,
    output logic                               rsp_valid,
    input  wire logic                          rsp_ready,
    output logic                               rsp_status,
    output logic      [prl_pkg::WORD_W-1:0]    rsp_read_id,
    output logic      [prl_pkg::WORD_W-1:0]    rsp_read_name,
    output logic      [prl_pkg::AGE_W-1:0]     rsp_read_age,
    output logic      [prl_pkg::LEN_W-1:0]     rsp_list_length
);
    import prl_pkg::*;

    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int SW_W    = NAME_BYTES * 8;
    localparam int REC_W   = 2 * SW_W + AGE_W;
    localparam int WIDE_W  = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int LWIDE_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;

    // captured request
    action_t           action_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [SW_W-1:0]   id_reg;
    logic [SW_W-1:0]   name_reg;
    logic [AGE_W-1:0]  age_reg;

    // list state and shift loop
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [ADDR_W-1:0] src_reg;
    logic [ADDR_W-1:0] src_next;
    logic [ADDR_W-1:0] wptr_reg;
    logic [ADDR_W-1:0] wptr_next;
    logic [CNT_W-1:0]  remain_reg;
    logic [CNT_W-1:0]  remain_next;
    logic              pend_reg;
    logic              pend_next;

    // response register
    logic              rsp_valid_reg;
    logic              rsp_status_reg;
    logic [WORD_W-1:0] rsp_id_reg;
    logic [WORD_W-1:0] rsp_name_reg;
    logic [AGE_W-1:0]  rsp_age_reg;
    logic [LEN_W-1:0]  rsp_len_reg;

    logic [WIDE_W-1:0]  pos_wide;
    logic [WIDE_W-1:0]  cnt_wide;
    logic [ADDR_W-1:0]  pos_addr;
    logic [CNT_W-1:0]   pos_cnt;
    logic [LWIDE_W-1:0] len_wide;
    logic               full;
    logic               out_range;
    logic               refused;
    logic               is_delete;

    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [REC_W-1:0]   ram_wdata;
    logic               ram_re;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [REC_W-1:0]   ram_rdata;

    assign pos_wide  = WIDE_W'(pos_reg);
    assign cnt_wide  = WIDE_W'(count_reg);
    assign pos_addr  = pos_wide[ADDR_W-1:0];
    assign pos_cnt   = pos_wide[CNT_W-1:0];
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign out_range = (pos_wide >= cnt_wide);
    assign is_delete = (action_reg == ACT_DELETE);

    always_comb
    begin
        unique case (action_reg)
            ACT_APPEND: refused = full;
            ACT_READ:   refused = out_range;
            ACT_DELETE: refused = out_range;
            ACT_INSERT: refused = out_range || full;
        endcase
    end

    assign stat.action     = action_reg;
    assign stat.refused    = refused;
    assign stat.shift_done = (remain_reg == '0) && !pend_reg;
    assign stat.out_free   = !rsp_valid_reg || rsp_ready;

    // shift loop: one copy issued and one retired per cycle
    always_comb
    begin
        src_next    = src_reg;
        wptr_next   = wptr_reg;
        remain_next = remain_reg;
        pend_next   = pend_reg;
        ram_re      = 1'b0;
        ram_raddr   = src_reg;
        if (cmd.shift_init)
        begin
            pend_next = 1'b0;
            if (is_delete)
            begin
                src_next    = pos_addr + ADDR_W'(1);
                remain_next = count_reg - pos_cnt - CNT_W'(1);
            end
            else
            begin
                src_next    = count_reg[ADDR_W-1:0] - ADDR_W'(1);
                remain_next = count_reg - pos_cnt;
            end
        end
        else if (cmd.shift_step)
        begin
            if (remain_reg != '0)
            begin
                ram_re      = 1'b1;
                pend_next   = 1'b1;
                remain_next = remain_reg - CNT_W'(1);
                if (is_delete)
                begin
                    wptr_next = src_reg - ADDR_W'(1);
                    src_next  = src_reg + ADDR_W'(1);
                end
                else
                begin
                    wptr_next = src_reg + ADDR_W'(1);
                    src_next  = src_reg - ADDR_W'(1);
                end
            end
            else
            begin
                pend_next = 1'b0;
            end
        end
        else if (cmd.read_issue)
        begin
            ram_re    = 1'b1;
            ram_raddr = pos_addr;
        end
    end

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = wptr_reg;
        ram_wdata = ram_rdata;
        if (cmd.write_new)
        begin
            ram_we    = 1'b1;
            ram_waddr = (action_reg == ACT_APPEND) ? count_reg[ADDR_W-1:0] : pos_addr;
            ram_wdata = {id_reg, name_reg, age_reg};
        end
        else if (cmd.shift_step && pend_reg)
        begin
            ram_we = 1'b1;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (!refused)
        begin
            unique case (action_reg)
                ACT_APPEND, ACT_INSERT: count_next = count_reg + CNT_W'(1);
                ACT_DELETE:             count_next = count_reg - CNT_W'(1);
                ACT_READ:               count_next = count_reg;
            endcase
        end
    end

    assign len_wide = LWIDE_W'(count_next);

    prl_ram #(
        .WIDTH (REC_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // request word, only the low name bytes are kept
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            pos_reg  <= req_position;
            id_reg   <= req_entry_id[SW_W-1:0];
            name_reg <= req_entry_name[SW_W-1:0];
            age_reg  <= req_entry_age;
        end
        src_reg  <= src_next;
        wptr_reg <= wptr_next;
        if (cmd.result_load)
        begin
            rsp_status_reg <= refused;
            rsp_len_reg    <= len_wide[LEN_W-1:0];
            if ((action_reg == ACT_READ) && !refused)
            begin
                rsp_id_reg   <= WORD_W'(ram_rdata[REC_W-1 -: SW_W]);
                rsp_name_reg <= WORD_W'(ram_rdata[AGE_W +: SW_W]);
                rsp_age_reg  <= ram_rdata[AGE_W-1:0];
            end
            else
            begin
                rsp_id_reg   <= '0;
                rsp_name_reg <= '0;
                rsp_age_reg  <= '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            action_reg    <= ACT_APPEND;
            count_reg     <= '0;
            remain_reg    <= '0;
            pend_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.capture)
            begin
                action_reg <= action_t'(req_action);
            end
            if (cmd.result_load)
            begin
                count_reg <= count_next;
            end
            remain_reg <= remain_next;
            pend_reg   <= pend_next;
            if (cmd.result_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp_valid       = rsp_valid_reg;
    assign rsp_status      = rsp_status_reg;
    assign rsp_read_id     = rsp_id_reg;
    assign rsp_read_name   = rsp_name_reg;
    assign rsp_read_age    = rsp_age_reg;
    assign rsp_list_length = rsp_len_reg;

`ifndef SYNTH
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("record count above depth");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.result_load |-> (!rsp_valid_reg || rsp_ready))
        else $error("response overwritten before taken");

    a_no_wr_clash: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.write_new && pend_reg))
        else $error("new record write collides with pending copy");

    a_remain_bound: assert property (@(posedge clk) disable iff (!rst_n)
        remain_reg <= count_reg)
        else $error("shift count beyond list length");
`endif

endmodule

`default_nettype wire

// File: hdl/positional_record_list_core.sv
// ----------------------------------------------------------------------------
// positional_record_list_core
// ordered list of records with append, read, delete and insert by position
// ----------------------------------------------------------------------------
// Holds up to DEPTH records (identifier word, name word, age) in one ram and
// answers every request word with exactly one response word carrying status,
// the record read and the new length. One request is worked at a time: append,
// read and a refused request go from the decision straight to the response;
// delete first moves the length - position - 1 records behind the position
// and insert the length - position records from the position on. The shift
// loop moves one record per cycle through the ram's single write and single
// read port. A new request word is taken while the previous response word
// still waits in the output register. No clearing pass runs after reset: the
// length counter alone tells which slots are live, and slots past it are never
// read.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_record_list_core #(
    parameter int DEPTH      = prl_pkg::DEPTH_DEF,
    parameter int NAME_BYTES = prl_pkg::NAME_BYTES_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    prl_req_if.sink   req,
    prl_rsp_if.source rsp
);
    import prl_pkg::*;

    // command and status between sequencer and datapath
    prl_cmd_t  cmd;
    prl_stat_t stat;

    // sequencer owns the request handshake
    prl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // datapath holds the store, the length and the response word
    prl_datapath #(
        .DEPTH      (DEPTH),
        .NAME_BYTES (NAME_BYTES)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .req_action      (req.action),
        .req_position    (req.position),
        .req_entry_id    (req.entry_id),
        .req_entry_name  (req.entry_name),
        .req_entry_age   (req.entry_age),
        .rsp_valid       (rsp.valid),
        .rsp_ready       (rsp.ready),
        .rsp_status      (rsp.status),
        .rsp_read_id     (rsp.read_id),
        .rsp_read_name   (rsp.read_name),
        .rsp_read_age    (rsp.read_age),
        .rsp_list_length (rsp.list_length)
    );

endmodule

`default_nettype wire

// File: bench/prl_list_tracker_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prl_tb_pkg
// shadow copy of the record list and the queue of awaited response words
// ----------------------------------------------------------------------------

package prl_tb_pkg;
    import prl_pkg::*;

    typedef struct packed {
        logic              status;
        logic [WORD_W-1:0] read_id;
        logic [WORD_W-1:0] read_name;
        logic [AGE_W-1:0]  read_age;
        logic [LEN_W-1:0]  list_length;
    } list_reply_t;

    class record_list_tracker #(int DEPTH = 64, int NAME_BYTES = 8);
        logic [WORD_W-1:0] id_slot   [DEPTH];
        logic [WORD_W-1:0] name_slot [DEPTH];
        logic [AGE_W-1:0]  age_slot  [DEPTH];
        logic [WORD_W-1:0] keep_mask;
        int unsigned       held;
        int unsigned       peak;
        int unsigned       mismatches;
        int unsigned       refusals;
        int unsigned       full_refusals;
        int unsigned       accepted [4];
        list_reply_t       awaited [$];

        function new();
            foreach (id_slot[i])
            begin
                id_slot[i]   = '0;
                name_slot[i] = '0;
                age_slot[i]  = '0;
            end
            // only the low NAME_BYTES bytes of a word are kept
            keep_mask = (NAME_BYTES >= 8) ? '1 : ((64'd1 << (NAME_BYTES * 8)) - 64'd1);
            held = 0;
            peak = 0;
            mismatches = 0;
            refusals = 0;
            full_refusals = 0;
            foreach (accepted[i])
                accepted[i] = 0;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function void move_slot(int unsigned dst, int unsigned src);
            id_slot[dst]   = id_slot[src];
            name_slot[dst] = name_slot[src];
            age_slot[dst]  = age_slot[src];
        endfunction

        function void put_slot(int unsigned dst, logic [WORD_W-1:0] id,
                               logic [WORD_W-1:0] name, logic [AGE_W-1:0] age);
            id_slot[dst]   = id & keep_mask;
            name_slot[dst] = name & keep_mask;
            age_slot[dst]  = age;
        endfunction

        // apply one accepted request word to the shadow list, queue its reply
        function void note_request(action_t act, logic [POS_W-1:0] pos,
                                   logic [WORD_W-1:0] id, logic [WORD_W-1:0] name,
                                   logic [AGE_W-1:0] age);
            list_reply_t rep;
            int unsigned p;
            int unsigned i;
            rep = '0;
            p = pos;
            accepted[act]++;
            case (act)
                ACT_APPEND:
                begin
                    if (held >= DEPTH)
                        rep.status = 1'b1;
                    else
                    begin
                        put_slot(held, id, name, age);
                        held++;
                    end
                end
                ACT_READ:
                begin
                    if (p >= held)
                        rep.status = 1'b1;
                    else
                    begin
                        rep.read_id   = id_slot[p];
                        rep.read_name = name_slot[p];
                        rep.read_age  = age_slot[p];
                    end
                end
                ACT_DELETE:
                begin
                    if (p >= held)
                        rep.status = 1'b1;
                    else
                    begin
                        for (i = p; i + 1 < held; i++)
                            move_slot(i, i + 1);
                        put_slot(held - 1, '0, '0, '0);
                        held--;
                    end
                end
                default:
                begin
                    // insert only before a live entry, never at the tail
                    if (p >= held || held >= DEPTH)
                        rep.status = 1'b1;
                    else
                    begin
                        for (i = held; i > p; i--)
                            move_slot(i, i - 1);
                        put_slot(p, id, name, age);
                        held++;
                    end
                end
            endcase
            rep.list_length = LEN_W'(held);
            if (rep.status)
            begin
                refusals++;
                if (held == DEPTH)
                    full_refusals++;
            end
            if (held > peak)
                peak = held;
            awaited.push_back(rep);
        endfunction

        function void compare_field(string label, logic [WORD_W-1:0] want,
                                    logic [WORD_W-1:0] got);
            if (got !== want)
            begin
                mismatches++;
                $display("%0t: %s mismatch, expected %h, actual %h", $time, label, want, got);
            end
        endfunction

        function void check_response(logic status, logic [WORD_W-1:0] read_id,
                                     logic [WORD_W-1:0] read_name,
                                     logic [AGE_W-1:0] read_age,
                                     logic [LEN_W-1:0] list_length);
            list_reply_t want;
            if (awaited.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected response word, expected none, actual status %b length %0d",
                         $time, status, list_length);
                return;
            end
            want = awaited.pop_front();
            compare_field("status", want.status, status);
            compare_field("read_id", want.read_id, read_id);
            compare_field("read_name", want.read_name, read_name);
            compare_field("read_age", want.read_age, read_age);
            compare_field("list_length", want.list_length, list_length);
        endfunction

        function void flag_leftovers();
            if (awaited.size() != 0)
            begin
                mismatches++;
                $display("%0t: %0d response words never arrived, expected 0 pending, actual %0d",
                         $time, awaited.size(), awaited.size());
            end
        endfunction
    endclass

endpackage

// File: bench/positional_record_list_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_record_list_core_tb
// self-checking bench for the positional record list
// ----------------------------------------------------------------------------
// Drives request words through the valid/ready request channel, keeps a shadow
// copy of the list and compares every response word field by field. A short
// directed run covers the empty list, out-of-range positions, insert at the
// tail, the word extremes and each action; random phases then grow the list to
// full, shrink it to empty and mix actions, with random gaps on both sides and
// long receiver stalls that back the core up into its request port.
// ----------------------------------------------------------------------------

module positional_record_list_core_tb;
    import prl_pkg::*;
    import prl_tb_pkg::*;

    localparam int DEPTH         = DEPTH_DEF;
    localparam int NAME_BYTES    = NAME_BYTES_DEF;
    localparam int RANDOM_ITEMS  = 1900;
    localparam int STALL_CYCLES  = 400;
    localparam int DRAIN_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = DEPTH + 8;

    // random phases: fill up, empty out, or an even mix of actions
    typedef enum int {
        PH_GROW,
        PH_SHRINK,
        PH_MIXED
    } phase_t;

    // scoreboard class sized like the core
    typedef prl_tb_pkg::record_list_tracker #(
        .DEPTH      (DEPTH),
        .NAME_BYTES (NAME_BYTES)
    ) tracker_t;

    logic clk = 1'b0;
    logic rst_n;

    prl_req_if req_ch ();
    prl_rsp_if rsp_ch ();

    positional_record_list_core #(
        .DEPTH      (DEPTH),
        .NAME_BYTES (NAME_BYTES)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    tracker_t tracker = new();

    // when set, the side in question stops idling for a stretch of words
    bit          sender_calm   = 1'b0;
    bit          receiver_calm = 1'b0;
    int unsigned replies_seen  = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int draw_wait(bit calm);
        return calm ? 0 : $urandom_range(0, 3);
    endfunction

    // mostly random words, now and then all ones or all zeros
    function automatic logic [WORD_W-1:0] rand_word();
        case ($urandom_range(0, 9))
            0:       return '1;
            1:       return '0;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // offer one request word, hold it until taken, then note it and idle a while
    task automatic send_word(action_t act, logic [POS_W-1:0] pos,
                             logic [WORD_W-1:0] id, logic [WORD_W-1:0] name,
                             logic [AGE_W-1:0] age);
        int gap;
        req_ch.valid      <= 1'b1;
        req_ch.action     <= act;
        req_ch.position   <= pos;
        req_ch.entry_id   <= id;
        req_ch.entry_name <= name;
        req_ch.entry_age  <= age;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        tracker.note_request(act, pos, id, name, age);
        gap = draw_wait(sender_calm);
        // with no gap valid simply stays high for the next word
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // one random word shaped by the phase; positions mostly land inside the list
    task automatic send_random(phase_t ph);
        action_t          act;
        logic [POS_W-1:0] pos;
        int               r;
        int unsigned      held;
        held = tracker.held;
        r = $urandom_range(0, 99);
        case (ph)
            PH_GROW:
                act = (r < 45) ? ACT_APPEND : (r < 80) ? ACT_INSERT :
                      (r < 93) ? ACT_READ : ACT_DELETE;
            PH_SHRINK:
                act = (r < 55) ? ACT_DELETE : (r < 75) ? ACT_READ :
                      (r < 88) ? ACT_APPEND : ACT_INSERT;
            default:
                act = (r < 25) ? ACT_APPEND : (r < 50) ? ACT_READ :
                      (r < 75) ? ACT_DELETE : ACT_INSERT;
        endcase
        if (act == ACT_APPEND || held == 0)
            pos = POS_W'($urandom_range(0, DEPTH - 1));
        else if (held < DEPTH && $urandom_range(0, 9) == 0)
            pos = POS_W'($urandom_range(held, DEPTH - 1));   // out of range, incl. the tail
        else
            pos = POS_W'($urandom_range(0, held - 1));
        send_word(act, pos, rand_word(), rand_word(), AGE_W'($urandom_range(0, 255)));
    endtask

    // stimulus and end of run
    initial
    begin
        int     random_sent;
        int     steps;
        int     extra;
        bit     done;
        phase_t ph;

        rst_n             <= 1'b0;
        req_ch.valid      <= 1'b0;
        req_ch.action     <= ACT_APPEND;
        req_ch.position   <= '0;
        req_ch.entry_id   <= '0;
        req_ch.entry_name <= '0;
        req_ch.entry_age  <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // empty list: nothing to read, delete or insert before
        send_word(ACT_READ, 6'd0, '0, '0, '0);
        send_word(ACT_DELETE, 6'd0, '0, '0, '0);
        send_word(ACT_INSERT, 6'd0, '1, '1, 8'hff);
        // appends with extreme words and ages, position ignored
        send_word(ACT_APPEND, 6'd63, '1, '1, 8'hff);
        send_word(ACT_APPEND, 6'd0, '0, '0, 8'h00);
        send_word(ACT_APPEND, 6'd21, rand_word(), rand_word(),
                  AGE_W'($urandom_range(0, 255)));
        send_word(ACT_READ, 6'd0, '0, '0, '0);
        send_word(ACT_READ, 6'd2, '0, '0, '0);
        send_word(ACT_READ, 6'd3, '0, '0, '0);       // one past the end
        send_word(ACT_READ, 6'd63, '1, '1, 8'hff);   // far out, payload ignored
        // insert at the head and before the last entry, then at the tail
        send_word(ACT_INSERT, 6'd0, rand_word(), rand_word(),
                  AGE_W'($urandom_range(0, 255)));
        send_word(ACT_INSERT, 6'd3, rand_word(), rand_word(),
                  AGE_W'($urandom_range(0, 255)));
        send_word(ACT_INSERT, 6'd5, rand_word(), rand_word(),
                  AGE_W'($urandom_range(0, 255)));
        send_word(ACT_READ, 6'd0, '0, '0, '0);
        send_word(ACT_READ, 6'd4, '0, '0, '0);
        // delete front, last and middle, then out of range
        send_word(ACT_DELETE, 6'd0, '0, '0, '0);
        send_word(ACT_DELETE, 6'd3, '0, '0, '0);
        send_word(ACT_DELETE, 6'd1, '0, '0, '0);
        send_word(ACT_DELETE, 6'd63, '0, '0, '0);
        send_word(ACT_READ, 6'd1, '0, '0, '0);

        // random phases; grow runs past full and shrink past empty so that
        // the full and empty refusals keep coming up
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            ph = phase_t'($urandom_range(0, 2));
            steps = 0;
            extra = 0;
            done = 1'b0;
            while (!done && random_sent < RANDOM_ITEMS)
            begin
                if (random_sent % 128 == 0)
                    sender_calm = ($urandom_range(0, 3) == 0);
                send_random(ph);
                random_sent++;
                steps++;
                case (ph)
                    PH_GROW:
                    begin
                        if (tracker.held == DEPTH)
                            extra++;
                        done = (extra >= 4) || (steps >= 300);
                    end
                    PH_SHRINK:
                    begin
                        if (tracker.held == 0)
                            extra++;
                        done = (extra >= 3) || (steps >= 300);
                    end
                    default:
                        done = (steps >= 60);
                endcase
            end
        end
        req_ch.valid <= 1'b0;

        // let the last responses drain, then watch for strays
        steps = 0;
        while (tracker.pending() != 0 && steps < DRAIN_LIMIT)
        begin
            @(posedge clk);
            steps++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        tracker.flag_leftovers();

        $display("covered %0d requests: %0d append, %0d read, %0d delete, %0d insert",
                 tracker.accepted[ACT_APPEND] + tracker.accepted[ACT_READ] +
                 tracker.accepted[ACT_DELETE] + tracker.accepted[ACT_INSERT],
                 tracker.accepted[ACT_APPEND], tracker.accepted[ACT_READ],
                 tracker.accepted[ACT_DELETE], tracker.accepted[ACT_INSERT]);
        $display("%0d refused (%0d on a full list), longest list %0d of %0d, %0d responses",
                 tracker.refusals, tracker.full_refusals, tracker.peak, DEPTH, replies_seen);
        if (tracker.mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // response side: random ready gaps, two long stalls to back up the core
    initial
    begin
        int hold;
        rsp_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (replies_seen == 300 || replies_seen == 1100)
                hold = STALL_CYCLES;
            else
                hold = draw_wait(receiver_calm);
            if (hold > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (rsp_ch.valid !== 1'b1);
            tracker.check_response(rsp_ch.status, rsp_ch.read_id, rsp_ch.read_name,
                                   rsp_ch.read_age, rsp_ch.list_length);
            replies_seen++;
            if (replies_seen % 100 == 0)
                receiver_calm = ($urandom_range(0, 3) == 0);
        end
    end

    // hang guard, several times the slowest correct run
    initial
    begin
        #3_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
